/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LoG filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/logf5_pkg.sv */
// ----------------------------------------------------------------------------
// LoG filter package
// Types, register indexes and fixed constants of the 5x5 LoG gray filter.
// ----------------------------------------------------------------------------
package logf5_pkg;

  localparam int KERNEL_SIZE = 5;
  localparam int NUM_LINES = 4;
  localparam int NUM_CLASSES = 6;
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CLASS_SUM_W = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH = 11'd128;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 11'd128;

  // Q16 luma weights.
  localparam logic [15:0] GRAY_W_RED = 16'd13933;
  localparam logic [15:0] GRAY_W_GREEN = 16'd46871;
  localparam logic [15:0] GRAY_W_BLUE = 16'd4732;

  // Q20 kernel values by squared distance from the center: 0, 1, 2, 4, 5, 8.
  localparam int unsigned COEF_Q20 [NUM_CLASSES] = '{
    32'd88079, 32'd74062, 32'd61302, 32'd39182, 32'd29652, 32'd6275
  };

  typedef logic [NUM_LINES-1:0][7:0] line_word_t;
  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] win_t;
  typedef logic [KERNEL_SIZE-1:0][7:0] win_col_t;

  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [7:0] data;
  } line_wr_t;

  function automatic int unsigned coef_round(input int idx, input int frac);
    return (COEF_Q20[idx] + (32'd1 << (19 - frac))) >> (20 - frac);
  endfunction

endpackage

/* rtl/core/logf5_line_mem.sv */
// ----------------------------------------------------------------------------
// LoG filter line store
// One word per column holding that column's gray value for four image rows;
// registered read, per-row byte write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module logf5_line_mem import logf5_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output line_word_t    rd_data,
  input  line_wr_t      wr,
  input  logic [AW-1:0] wr_addr
);

  line_word_t mem [DEPTH];
  line_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr.en) begin
      mem[wr_addr][wr.lane] <= wr.data;
    end
  end

  assign rd_data = rd_data_r;

  `ASSERT_IMP(a_no_same_entry, clk, rst_n, rd_en && wr.en, rd_addr != wr_addr,
    "line store read and write hit the same column in one cycle")

endmodule

/* rtl/core/log_filter_5x5_gray_unit.sv */
// ----------------------------------------------------------------------------
// 5x5 Laplacian-of-Gaussian gray filter
// Converts RGB to gray, buffers four rows in a column-wide line store and
// applies a sigma 3 LoG kernel over a 5x5 window on a padded raster.
// ----------------------------------------------------------------------------
// Channel  Side    Beat contents
// in_*     slave   tdata: red[7:0], green[15:8], blue[23:16]
// out_*    master  tdata: filtered[7:0]; tlast: frame_end
// cfg_*    slave   index 0 image_width, 1 image_height; data[10:0]
//
// One pixel beat is taken per cycle while not stalled; the line store's one
// read and one byte write per cycle set that rate.
// A result passes the stage 1, window, sum, product and output registers.
// Reset is synchronous, clears position and pipeline valids and sets the
// geometry to 128 by 128; the line store is not cleared.
// Output backpressure stalls the pipeline stage by stage; empty stages keep
// taking beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module log_filter_5x5_gray_unit import logf5_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [23:0]            in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // filtered[7:0]
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 3);
  localparam int ACC_W = COEF_FRAC_BITS + 10;
  localparam int unsigned COEF [NUM_CLASSES] = '{
    coef_round(0, COEF_FRAC_BITS), coef_round(1, COEF_FRAC_BITS),
    coef_round(2, COEF_FRAC_BITS), coef_round(3, COEF_FRAC_BITS),
    coef_round(4, COEF_FRAC_BITS), coef_round(5, COEF_FRAC_BITS)
  };

  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;

  logic [CW-1:0]    eff_w, wext, xa;
  logic [ROW_W-1:0] eff_h, hext, ya;
  logic             col_in, inside0, emit0, last0, last_col;
  logic [NUM_LINES-1:0] line_ok0;

  logic in_fire, cfg_fire;
  logic ld1, ld2, ld3, ld4, go_out;

  logic                 v1_r;
  logic [7:0]           red1_r, green1_r, blue1_r;
  logic [AW-1:0]        x1_r;
  logic [1:0]           lane1_r;
  logic [NUM_LINES-1:0] line_ok1_r;
  logic                 inside1_r, emit1_r, last1_r, zero1_r;

  line_word_t rd_data;
  line_wr_t   wr;
  logic [23:0] gsum;
  logic [7:0]  gray1;
  logic [1:0]  lsel;
  win_col_t    col_new;
  win_t        window_r, window_nxt;

  logic v2_r, emit2_r, last2_r;

  logic                   v3_r, last3_r;
  logic [CLASS_SUM_W-1:0] sum_nxt [NUM_CLASSES];
  logic [CLASS_SUM_W-1:0] sum_r [NUM_CLASSES];

  logic             v4_r, last4_r;
  logic [ACC_W-1:0] prod_r [NUM_CLASSES];
  logic [ACC_W-1:0] acc, acc_sh;

  logic       out_valid_r, out_last_r;
  logic [7:0] out_data_r;

  // Geometry and position ---------------------------------------------------
  always_comb begin
    if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
    wext = eff_w + CW'(2);
    hext = eff_h + ROW_W'(2);

    xa = col_r;
    ya = row_r;
    if (col_r >= wext) begin
      xa = '0;
      ya = row_r + ROW_W'(1);
    end
    if (ya >= hext) begin
      xa = '0;
      ya = '0;
    end

    col_in = xa < eff_w;
    inside0 = col_in && (ya < eff_h);
    for (int k = 1; k <= NUM_LINES; k++) begin
      line_ok0[k-1] = (ya >= ROW_W'(k)) && ((ya - ROW_W'(k)) < eff_h) && col_in;
    end
    emit0 = (xa >= CW'(2)) && (ya >= ROW_W'(2));
    last_col = xa == (wext - CW'(1));
    last0 = last_col && (ya == (hext - ROW_W'(1)));

    col_nxt = last_col ? '0 : xa + CW'(1);
    if (!last_col) begin
      row_nxt = ya;
    end else if (ya == (hext - ROW_W'(1))) begin
      row_nxt = '0;
    end else begin
      row_nxt = ya + ROW_W'(1);
    end
  end

  // Stage handshake ---------------------------------------------------------
  assign go_out = !out_valid_r || out_tready;
  assign ld4 = !v4_r || go_out;
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;

  assign in_tready = ld1;
  assign in_fire = in_tvalid && ld1;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      col_r <= '0;
      row_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_r <= cfg_data;
          end
          REG_IMAGE_HEIGHT: begin
            height_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (ld1) begin
        v1_r <= in_tvalid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r && emit2_r;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (go_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  // Stage 1: line store read, gray conversion -------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      red1_r <= in_tdata[7:0];
      green1_r <= in_tdata[15:8];
      blue1_r <= in_tdata[23:16];
      x1_r <= xa[AW-1:0];
      lane1_r <= ya[1:0];
      line_ok1_r <= line_ok0;
      inside1_r <= inside0;
      emit1_r <= emit0;
      last1_r <= last0;
      zero1_r <= xa == '0;
    end
  end

  logf5_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && col_in),
    .rd_addr (xa[AW-1:0]),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (x1_r)
  );

  always_comb begin
    lsel = '0;
    gsum = 24'(red1_r) * 24'(GRAY_W_RED) + 24'(green1_r) * 24'(GRAY_W_GREEN)
         + 24'(blue1_r) * 24'(GRAY_W_BLUE);
    gray1 = gsum[23:16];

    wr.en = v1_r && ld2 && inside1_r;
    wr.lane = lane1_r;
    wr.data = gray1;

    for (int k = 1; k <= NUM_LINES; k++) begin
      lsel = lane1_r - 2'(k);
      col_new[KERNEL_SIZE-1-k] = line_ok1_r[k-1] ? rd_data[lsel] : 8'd0;
    end
    col_new[KERNEL_SIZE-1] = inside1_r ? gray1 : 8'd0;

    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        window_nxt[r][c] = zero1_r ? 8'd0 : window_r[r][c+1];
      end
      window_nxt[r][KERNEL_SIZE-1] = col_new[r];
    end
  end

  // Stage 2: window ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      window_r <= window_nxt;
      emit2_r <= emit1_r;
      last2_r <= last1_r;
    end
  end

  // Stage 3: taps summed by kernel class ------------------------------------
  always_comb begin
    sum_nxt[0] = CLASS_SUM_W'(window_r[2][2]);
    sum_nxt[1] = CLASS_SUM_W'(window_r[1][2]) + CLASS_SUM_W'(window_r[2][1])
               + CLASS_SUM_W'(window_r[2][3]) + CLASS_SUM_W'(window_r[3][2]);
    sum_nxt[2] = CLASS_SUM_W'(window_r[1][1]) + CLASS_SUM_W'(window_r[1][3])
               + CLASS_SUM_W'(window_r[3][1]) + CLASS_SUM_W'(window_r[3][3]);
    sum_nxt[3] = CLASS_SUM_W'(window_r[0][2]) + CLASS_SUM_W'(window_r[2][0])
               + CLASS_SUM_W'(window_r[2][4]) + CLASS_SUM_W'(window_r[4][2]);
    sum_nxt[4] = CLASS_SUM_W'(window_r[0][1]) + CLASS_SUM_W'(window_r[0][3])
               + CLASS_SUM_W'(window_r[1][0]) + CLASS_SUM_W'(window_r[1][4])
               + CLASS_SUM_W'(window_r[3][0]) + CLASS_SUM_W'(window_r[3][4])
               + CLASS_SUM_W'(window_r[4][1]) + CLASS_SUM_W'(window_r[4][3]);
    sum_nxt[5] = CLASS_SUM_W'(window_r[0][0]) + CLASS_SUM_W'(window_r[0][4])
               + CLASS_SUM_W'(window_r[4][0]) + CLASS_SUM_W'(window_r[4][4]);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
      last3_r <= last2_r;
    end
  end

  // Stage 4: class products -------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        prod_r[i] <= ACC_W'(sum_r[i]) * ACC_W'(COEF[i]);
      end
      last4_r <= last3_r;
    end
  end

  // Output: accumulate, scale, clamp ----------------------------------------
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      acc = acc + prod_r[i];
    end
    acc_sh = acc >> COEF_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (go_out && v4_r) begin
      out_data_r <= (acc_sh > ACC_W'(255)) ? 8'hFF : acc_sh[7:0];
      out_last_r <= last4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  `ASSERT_IMP(a_stall_from_output, clk, rst_n, !in_tready, out_valid_r,
    "input stalled while the output register is empty")
  `ASSERT_NXT(a_stage1_holds, clk, rst_n, v1_r && !ld2, v1_r && $stable(x1_r),
    "stalled stage 1 lost or changed its pixel")
  `ASSERT_NXT(a_position_in_frame, clk, rst_n, in_fire && !cfg_fire,
    (col_r < wext) && (row_r < hext),
    "raster position left the padded frame")

endmodule
